/* hw/rtl/abss_pkg.sv */
`default_nettype none

package abss_pkg;

    localparam int CAPACITY = 128;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int WORD_W   = 32;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [WORD_W-1:0] word_t;

    localparam logic [1:0] KIND_ADD      = 2'd0;
    localparam logic [1:0] KIND_CONTAINS = 2'd1;
    localparam logic [1:0] KIND_REMOVE   = 2'd2;
    localparam logic [1:0] KIND_POP      = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;
    localparam logic [1:0] STAT_MISS  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_SCAN,
        ST_SHIFT,
        ST_TOP,
        ST_TOPW,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic  we;
        addr_t waddr;
        word_t wdata;
        logic  re;
        addr_t raddr;
    } ram_cmd_t;

    typedef struct packed {
        logic       found;
        word_t      top_value;
        logic [7:0] fill_count;
        logic       is_empty;
        logic [1:0] status;
    } res_t;

endpackage

`default_nettype wire

/* hw/rtl/abss_ram.sv */
`default_nettype none

module abss_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 128,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/abss_ctrl.sv */
`default_nettype none

module abss_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [1:0]       in_kind,
    input  wire abss_pkg::word_t  in_value,
    input  wire logic             out_free,
    output logic                  res_vld,
    output abss_pkg::res_t        res,
    output abss_pkg::ram_cmd_t    ram_cmd,
    input  wire abss_pkg::word_t  ram_rdata
);

    import abss_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] kind_reg, kind_next;
    word_t      val_reg, val_next;
    cnt_t       count_reg, count_next;
    word_t      top_reg, top_next;
    cnt_t       idx_reg, idx_next;
    cnt_t       cmp_idx_reg, cmp_idx_next;
    logic       cmp_vld_reg, cmp_vld_next;
    logic       found_reg, found_next;
    logic [1:0] status_reg, status_next;

    logic  accept;
    logic  issue;
    logic  hit;
    logic  full;
    cnt_t  wr_idx;
    cnt_t  last_idx;

    assign accept   = in_valid && in_ready;
    assign issue    = (idx_reg < count_reg);
    assign hit      = cmp_vld_reg && (ram_rdata == val_reg);
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign wr_idx   = cmp_idx_reg - CNT_W'(1);
    assign last_idx = count_reg - CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            top_reg     <= '0;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            top_reg     <= top_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        val_reg     <= val_next;
        idx_reg     <= idx_next;
        cmp_idx_reg <= cmp_idx_next;
        found_reg   <= found_next;
        status_reg  <= status_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_kind)
                        KIND_ADD:      state_next = full ? ST_DONE : ST_ADD;
                        KIND_CONTAINS: state_next = ST_SCAN;
                        KIND_REMOVE:   state_next = ST_SCAN;
                        default:       state_next = (count_reg == '0) ? ST_DONE : ST_TOP;
                    endcase
                end
            end
            ST_ADD:
            begin
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    state_next = (kind_reg == KIND_REMOVE) ? ST_SHIFT : ST_DONE;
                end
                else if (!issue && !cmp_vld_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SHIFT:
            begin
                if (!issue && !cmp_vld_reg)
                begin
                    state_next = ST_TOP;
                end
            end
            ST_TOP:
            begin
                state_next = (count_reg == '0) ? ST_DONE : ST_TOPW;
            end
            ST_TOPW:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory port
    always_comb
    begin
        kind_next    = kind_reg;
        val_next     = val_reg;
        count_next   = count_reg;
        top_next     = top_reg;
        idx_next     = idx_reg;
        cmp_idx_next = cmp_idx_reg;
        cmp_vld_next = 1'b0;
        found_next   = found_reg;
        status_next  = status_reg;
        ram_cmd      = '0;
        in_ready     = 1'b0;
        res_vld      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    kind_next   = in_kind;
                    val_next    = in_value;
                    idx_next    = '0;
                    found_next  = 1'b0;
                    status_next = STAT_OK;
                    case (in_kind)
                        KIND_ADD:
                        begin
                            if (full)
                            begin
                                status_next = STAT_FULL;
                            end
                        end
                        KIND_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                count_next = last_idx;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_ADD:
            begin
                ram_cmd.we    = 1'b1;
                ram_cmd.waddr = count_reg[ADDR_W-1:0];
                ram_cmd.wdata = val_reg;
                count_next    = count_reg + CNT_W'(1);
                top_next      = val_reg;
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                    idx_next   = cmp_idx_reg + CNT_W'(1);
                end
                else
                begin
                    if (issue)
                    begin
                        ram_cmd.re    = 1'b1;
                        ram_cmd.raddr = idx_reg[ADDR_W-1:0];
                        idx_next      = idx_reg + CNT_W'(1);
                        cmp_idx_next  = idx_reg;
                        cmp_vld_next  = 1'b1;
                    end
                    else if (!cmp_vld_reg && (kind_reg == KIND_REMOVE))
                    begin
                        status_next = STAT_MISS;
                    end
                end
            end
            ST_SHIFT:
            begin
                // move entry down one slot while the next one is read
                if (cmp_vld_reg)
                begin
                    ram_cmd.we    = 1'b1;
                    ram_cmd.waddr = wr_idx[ADDR_W-1:0];
                    ram_cmd.wdata = ram_rdata;
                end
                if (issue)
                begin
                    ram_cmd.re    = 1'b1;
                    ram_cmd.raddr = idx_reg[ADDR_W-1:0];
                    idx_next      = idx_reg + CNT_W'(1);
                    cmp_idx_next  = idx_reg;
                    cmp_vld_next  = 1'b1;
                end
                else if (!cmp_vld_reg)
                begin
                    count_next = last_idx;
                end
            end
            ST_TOP:
            begin
                if (count_reg == '0)
                begin
                    top_next = '0;
                end
                else
                begin
                    ram_cmd.re    = 1'b1;
                    ram_cmd.raddr = last_idx[ADDR_W-1:0];
                end
            end
            ST_TOPW:
            begin
                top_next = ram_rdata;
            end
            ST_DONE:
            begin
                res_vld = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign res.found      = found_reg;
    assign res.top_value  = top_reg;
    assign res.fill_count = count_reg[7:0];
    assign res.is_empty   = (count_reg == '0);
    assign res.status     = status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_DONE) |-> !ram_cmd.we)
        else $error("memory write outside an operation");

    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT && ram_cmd.we) |-> (wr_idx < count_reg))
        else $error("shift write beyond stored entries");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |=> ($stable(count_reg) && $stable(top_reg)))
        else $error("state changed while result pending");

endmodule

`default_nettype wire

/* hw/rtl/array_bag_stack_store.sv */
`default_nettype none

// channel  | dir | tdata                                   | tuser
// s_axis   | in  | item_value[31:0]                        | kind[1:0]
// m_axis   | out | found, top_value, fill_count, is_empty, | -
//          |     | status (48 bits, low to high)           |
//
// One beat in, one beat out. Contains makes a compare pass and remove a single
// compare-and-shift pass over the entry memory (one read and one write port).
// Reset clears the state, count, top and output valid; memory contents need no
// clearing. s_tready is high only between beats; a result waits in the output
// register while m_tready is low.

module array_bag_stack_store (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // item_value[31:0]
    input  wire logic [1:0]  s_tuser,   // kind[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata    // found, top_value[31:0], fill_count[7:0],
                                        // is_empty, status[1:0], zero pad
);

    import abss_pkg::*;

    ram_cmd_t ram_cmd;
    word_t    ram_rdata;
    res_t     res;
    logic     res_vld;
    logic     out_free;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [47:0] m_tdata_reg, m_tdata_next;

    assign out_free = !m_tvalid_reg || m_tready;

    abss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser),
        .in_value  (s_tdata),
        .out_free  (out_free),
        .res_vld   (res_vld),
        .res       (res),
        .ram_cmd   (ram_cmd),
        .ram_rdata (ram_rdata)
    );

    abss_ram #(
        .DATA_W (WORD_W),
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_cmd.we),
        .waddr (ram_cmd.waddr),
        .wdata (ram_cmd.wdata),
        .re    (ram_cmd.re),
        .raddr (ram_cmd.raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (res_vld && out_free)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {4'b0, res.status, res.is_empty, res.fill_count,
                             res.top_value, res.found};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
